>>> design/heavy_light_sketch_update_core_assert.svh
// Assertion macros shared by the sketch update core.
// Both expect signals named clk and arst_n in the enclosing module.
`ifndef HEAVY_LIGHT_SKETCH_UPDATE_CORE_ASSERT_SVH
`define HEAVY_LIGHT_SKETCH_UPDATE_CORE_ASSERT_SVH
// plain property, checked outside reset
`define HLSU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// antecedent holds -> consequent holds in the same cycle
`define HLSU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`endif

>>> design/hlsu_pkg.sv
// Shared types and constants of the sketch update core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hlsu_pkg;
	localparam int KEY_FIELD_W = 32;
	localparam int IN_TDATA_W = 56;   // key, heavy index, light index
	localparam int OUT_TDATA_W = 48;  // slot, estimate, light count

	localparam logic [2:0] OUTC_HIT = 3'd0;
	localparam logic [2:0] OUTC_NEW = 3'd1;
	localparam logic [2:0] OUTC_LIGHT = 3'd2;
	localparam logic [2:0] OUTC_EVICT = 3'd3;
	localparam logic [2:0] OUTC_QUERY = 3'd4;
	localparam logic [2:0] NO_SLOT = 3'd7;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic [31:0] VOTE_MAX = 32'hFFFF_FFFF;
	localparam logic [7:0] LIGHT_MAX = 8'd255;
	localparam logic [7:0] RATIO_RESET = 8'd8;

	typedef struct packed {
		logic clr;   // clearing pass, one row per cycle
		logic load;  // input word accepted
		logic quot;  // index quotients
		logic rd;    // index remainders, memory reads
		logic eval;  // slot search
		logic upd;   // write back, load result
	} hlsu_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic out_free;
	} hlsu_sts_t;
endpackage
`default_nettype wire

>>> design/hlsu_ctrl.sv
// Sequencer of the sketch update core: clear pass, then one item at a time.
// Depends on hlsu_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "heavy_light_sketch_update_core_assert.svh"
module hlsu_ctrl
	import hlsu_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      s_tvalid,
	output logic           s_tready,
	input  wire hlsu_sts_t sts,
	output hlsu_cmd_t      cmd
);
	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_QUOT  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_EVAL  = 6'b010000,
		ST_UPD   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = ST_QUOT;
				end
			end
			ST_QUOT: begin
				cmd.quot = 1'b1;
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				// hold until the result register can take the word
				if (sts.out_free) begin
					cmd.upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`HLSU_ASSERT(a_load_then_quot, (cmd.load |=> state_q == ST_QUOT),
		"accepted word did not start the quotient step")
	`HLSU_ASSERT_IMP(a_upd_free, cmd.upd, sts.out_free,
		"result loaded while output register busy")
	`HLSU_ASSERT(a_clear_exit, ((state_q == ST_CLEAR && sts.clr_done) |=> s_tready),
		"clearing pass did not hand over to idle")
	`HLSU_ASSERT_IMP(a_no_accept_clear, cmd.clr, !s_tready,
		"input taken during clearing pass")
endmodule
`default_nettype wire

>>> design/hlsu_dp.sv
// Datapath of the sketch update core: index reduction, bucket, negative vote
// and light counter memories, slot search, update and result register. Uses hlsu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hlsu_dp
	import hlsu_pkg::*;
#(
	parameter int HEAVY_BUCKETS = 1024,
	parameter int BUCKET_ENTRIES = 8,
	parameter int LIGHT_COUNTERS = 4096,
	parameter int KEY_BYTES = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire hlsu_cmd_t              cmd,
	output hlsu_sts_t                   sts,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                   s_tuser,
	input  wire logic                   cfg_we,
	input  wire logic [7:0]             cfg_wdata,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic [2:0]                  m_tuser
);
	localparam int SLOTS = BUCKET_ENTRIES - 1;
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KW = 8 * ((KEY_BYTES < 4) ? KEY_BYTES : 4);
	localparam int HIW = (HEAVY_BUCKETS > 1) ? $clog2(HEAVY_BUCKETS) : 1;
	localparam int LIW = (LIGHT_COUNTERS > 1) ? $clog2(LIGHT_COUNTERS) : 1;
	localparam int MAXR = (HEAVY_BUCKETS > LIGHT_COUNTERS) ? HEAVY_BUCKETS : LIGHT_COUNTERS;
	localparam int CW = (MAXR > 1) ? $clog2(MAXR) : 1;
	// reciprocal constants, exact for 10- and 12-bit dividends
	localparam longint HM_L = ((64'd1 << 26) + HEAVY_BUCKETS - 1) / HEAVY_BUCKETS;
	localparam longint LM_L = ((64'd1 << 32) + LIGHT_COUNTERS - 1) / LIGHT_COUNTERS;
	localparam logic [26:0] HM = 27'(HM_L);
	localparam logic [32:0] LM = 33'(LM_L);

	// memories
	logic [SLOTS-1:0][KW-1:0] key_mem [HEAVY_BUCKETS];
	logic [SLOTS-1:0][31:0]   vote_mem [HEAVY_BUCKETS];
	logic [SLOTS-1:0]         spill_mem [HEAVY_BUCKETS];
	logic [31:0]              neg_mem [HEAVY_BUCKETS];
	logic [7:0]               light_mem [LIGHT_COUNTERS];

	logic [CW-1:0] clr_q;
	logic [7:0] ratio_q;
	logic mode_q;
	logic [KW-1:0] key_q;
	logic [9:0] hidx_q, hq_q;
	logic [11:0] lidx_q, lq_q;
	logic [HIW-1:0] hb_q;
	logic [LIW-1:0] li_q;
	logic [SLOTS-1:0][KW-1:0] key_rd_q;
	logic [SLOTS-1:0][31:0] vote_rd_q;
	logic [SLOTS-1:0] spill_rd_q;
	logic [31:0] neg_rd_q;
	logic [7:0] light_rd_q;
	logic sel_found_q, sel_match_q;
	logic [SW-1:0] sel_pos_q, min_pos_q;
	logic [31:0] min_vote_q;
	logic m_tvalid_q;
	logic [2:0] kind_q, slot_q;
	logic [31:0] est_q;
	logic [7:0] lc_q;

	// index reduction
	logic [36:0] hprod;
	logic [44:0] lprod;
	logic [26:0] hrem;
	logic [32:0] lrem;
	logic [HIW-1:0] hb_w;
	logic [LIW-1:0] li_w;

	assign hprod = 37'(hidx_q) * 37'(HM);
	assign lprod = 45'(lidx_q) * 45'(LM);
	assign hrem = 27'(hidx_q) - 27'(hq_q) * 27'(HEAVY_BUCKETS);
	assign lrem = 33'(lidx_q) - 33'(lq_q) * 33'(LIGHT_COUNTERS);
	assign hb_w = hrem[HIW-1:0];
	assign li_w = lrem[LIW-1:0];

	// config and item registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
			clr_q <= '0;
		end else begin
			if (cfg_we) begin
				ratio_q <= cfg_wdata;
			end
			if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= s_tuser;
			key_q <= s_tdata[KW-1:0];
			hidx_q <= s_tdata[41:32];
			lidx_q <= s_tdata[53:42];
		end
		if (cmd.quot) begin
			hq_q <= hprod[35:26];
			lq_q <= lprod[43:32];
		end
		if (cmd.rd) begin
			hb_q <= hb_w;
			li_q <= li_w;
		end
	end

	// slot search
	logic sel_found, sel_match, match;
	logic [SW-1:0] sel_pos, min_pos;
	logic [31:0] min_vote;

	always_comb begin
		sel_found = 1'b0;
		sel_match = 1'b0;
		sel_pos = '0;
		min_pos = '0;
		min_vote = vote_rd_q[0];
		match = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			match = (vote_rd_q[i] != '0) && (key_rd_q[i] == key_q);
			if (!sel_found && (match || (vote_rd_q[i] == '0 && mode_q == MODE_INSERT))) begin
				sel_found = 1'b1;
				sel_match = match;
				sel_pos = SW'(i);
			end
			if (vote_rd_q[i] < min_vote) begin
				min_vote = vote_rd_q[i];
				min_pos = SW'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			sel_found_q <= sel_found;
			sel_match_q <= sel_match;
			sel_pos_q <= sel_pos;
			min_pos_q <= min_pos;
			min_vote_q <= min_vote;
		end
	end

	// update
	logic [31:0] vote_s, neg_inc;
	logic spill_s, min_spill, evict;
	logic [39:0] prod;
	logic [32:0] lsum, qsum;
	logic [7:0] evict_lc, light_new;
	logic [2:0] kind_d, slot_d;
	logic [31:0] est_d;
	logic [SLOTS-1:0][KW-1:0] key_new;
	logic [SLOTS-1:0][31:0] vote_new;
	logic [SLOTS-1:0] spill_new;
	logic light_we;

	always_comb begin
		vote_s = vote_rd_q[sel_pos_q];
		spill_s = spill_rd_q[sel_pos_q];
		min_spill = spill_rd_q[min_pos_q];
		neg_inc = (neg_rd_q == VOTE_MAX) ? neg_rd_q : neg_rd_q + 32'd1;
		prod = 40'(min_vote_q) * 40'(ratio_q);
		evict = (prod <= 40'(neg_inc));
		lsum = 33'(light_rd_q) + 33'(min_vote_q);
		if (min_spill) begin
			evict_lc = (lsum > 33'(LIGHT_MAX)) ? LIGHT_MAX : lsum[7:0];
		end else begin
			evict_lc = (min_vote_q > 32'(LIGHT_MAX)) ? LIGHT_MAX : min_vote_q[7:0];
		end
		qsum = 33'(vote_s) + 33'(light_rd_q);
		key_new = key_rd_q;
		vote_new = vote_rd_q;
		spill_new = spill_rd_q;
		light_new = light_rd_q;
		light_we = 1'b0;
		slot_d = NO_SLOT;
		est_d = '0;
		if (mode_q == MODE_QUERY) begin
			kind_d = OUTC_QUERY;
			if (sel_found_q) begin
				slot_d = 3'(sel_pos_q);
				est_d = !spill_s ? vote_s : (qsum[32] ? VOTE_MAX : qsum[31:0]);
			end else begin
				est_d = 32'(light_rd_q);
			end
		end else if (sel_found_q && sel_match_q) begin
			kind_d = OUTC_HIT;
			slot_d = 3'(sel_pos_q);
			est_d = (vote_s == VOTE_MAX) ? vote_s : vote_s + 32'd1;
			vote_new[sel_pos_q] = est_d;
		end else if (sel_found_q) begin
			kind_d = OUTC_NEW;
			slot_d = 3'(sel_pos_q);
			est_d = 32'd1;
			vote_new[sel_pos_q] = 32'd1;
			key_new[sel_pos_q] = key_q;
			spill_new[sel_pos_q] = 1'b0;
		end else if (evict) begin
			kind_d = OUTC_EVICT;
			slot_d = 3'(min_pos_q);
			est_d = 32'd1;
			vote_new[min_pos_q] = 32'd1;
			key_new[min_pos_q] = key_q;
			spill_new[min_pos_q] = 1'b1;
			light_new = evict_lc;
			light_we = 1'b1;
		end else begin
			kind_d = OUTC_LIGHT;
			light_new = (light_rd_q == LIGHT_MAX) ? light_rd_q : light_rd_q + 8'd1;
			light_we = 1'b1;
		end
	end

	// memory ports: clearing pass or write back, one read per item
	logic heavy_clr, light_clr, ins_upd;
	assign heavy_clr = cmd.clr && ({1'b0, clr_q} < (CW + 1)'(HEAVY_BUCKETS));
	assign light_clr = cmd.clr && ({1'b0, clr_q} < (CW + 1)'(LIGHT_COUNTERS));
	assign ins_upd = cmd.upd && (mode_q == MODE_INSERT);

	always_ff @(posedge clk) begin
		if (heavy_clr) begin
			key_mem[clr_q[HIW-1:0]] <= '0;
			vote_mem[clr_q[HIW-1:0]] <= '0;
			spill_mem[clr_q[HIW-1:0]] <= '0;
			neg_mem[clr_q[HIW-1:0]] <= '0;
		end else if (ins_upd) begin
			key_mem[hb_q] <= key_new;
			vote_mem[hb_q] <= vote_new;
			spill_mem[hb_q] <= spill_new;
			if (!sel_found_q) begin
				neg_mem[hb_q] <= neg_inc;
			end
		end
		if (cmd.rd) begin
			key_rd_q <= key_mem[hb_w];
			vote_rd_q <= vote_mem[hb_w];
			spill_rd_q <= spill_mem[hb_w];
			neg_rd_q <= neg_mem[hb_w];
		end
	end

	always_ff @(posedge clk) begin
		if (light_clr) begin
			light_mem[clr_q[LIW-1:0]] <= '0;
		end else if (ins_upd && light_we) begin
			light_mem[li_q] <= light_new;
		end
		if (cmd.rd) begin
			light_rd_q <= light_mem[li_w];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.upd) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			kind_q <= kind_d;
			slot_q <= slot_d;
			est_q <= est_d;
			lc_q <= light_new;
		end
	end

	assign sts = '{clr_done: (clr_q == CW'(MAXR - 1)), out_free: (!m_tvalid_q || m_tready)};
	assign m_tvalid = m_tvalid_q;
	assign m_tuser = kind_q;
	assign m_tdata = {5'd0, lc_q, est_q, slot_q};
endmodule
`default_nettype wire

>>> design/heavy_light_sketch_update_core.sv
// An accepted input word passes quotient, read, search and write back, which
// waits for a free result register, then its result is valid; a new word is
// accepted only back in idle, as each item reads, modifies and writes a bucket row.
// Reset: asynchronous, active low; afterwards a clearing pass over
// max(HEAVY_BUCKETS, LIGHT_COUNTERS) rows zeroes all stores before s_tready rises.
`timescale 1ns / 1ps
`default_nettype none
module heavy_light_sketch_update_core
	import hlsu_pkg::*;
#(
	parameter int HEAVY_BUCKETS = 1024,
	parameter int BUCKET_ENTRIES = 8,
	parameter int LIGHT_COUNTERS = 4096,
	parameter int KEY_BYTES = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // flow_key, heavy_index, light_index
	input  wire logic                   s_tuser,   // mode
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // slot_used, estimate, light_count
	output logic [2:0]                  m_tuser,   // outcome
	input  wire logic                   cfg_we,
	input  wire logic [7:0]             cfg_wdata  // evict_ratio
);
	hlsu_cmd_t cmd;
	hlsu_sts_t sts;

	hlsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hlsu_dp #(
		.HEAVY_BUCKETS  (HEAVY_BUCKETS),
		.BUCKET_ENTRIES (BUCKET_ENTRIES),
		.LIGHT_COUNTERS (LIGHT_COUNTERS),
		.KEY_BYTES      (KEY_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);
endmodule
`default_nettype wire
